// ----- sv/cpfcv_pkg.sv -----
package cpfcv_pkg;

	// One input beat: a raw character and the end-of-string mark.
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_t;

	// One result beat.
	typedef struct packed {
		logic       cpf_ok;
		logic       cnpj_ok;
		logic       accepted;
		logic [3:0] digits_seen;
	} out_t;

	// A classified character as it travels through the queue.
	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       last;
	} entry_t;

	localparam logic [1:0] MODE_CPF    = 2'd0;
	localparam logic [1:0] MODE_CNPJ   = 2'd1;
	localparam logic [1:0] MODE_EITHER = 2'd2;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [3:0] CPF_LEN     = 4'd11;
	localparam logic [3:0] CNPJ_LEN    = 4'd14;
	localparam logic [3:0] COUNT_MAX   = 4'd15;
	localparam logic [3:0] POS_CPF_DV1  = 4'd9;
	localparam logic [3:0] POS_CPF_DV2  = 4'd10;
	localparam logic [3:0] POS_CNPJ_DV1 = 4'd12;
	localparam logic [3:0] POS_CNPJ_DV2 = 4'd13;

	// ceil(2^16 / 11); exact quotient for every 10-bit dividend.
	localparam logic [12:0] RECIP11 = 13'd5958;

	function automatic logic [3:0] cpf_w1(input logic [3:0] p);
		return (p < 4'd9) ? 4'(4'd10 - p) : 4'd0;
	endfunction

	function automatic logic [3:0] cpf_w2(input logic [3:0] p);
		return (p < 4'd10) ? 4'(4'd11 - p) : 4'd0;
	endfunction

	function automatic logic [3:0] cnpj_w1(input logic [3:0] p);
		logic [3:0] w;
		case (p)
			4'd0:    w = 4'd5;
			4'd1:    w = 4'd4;
			4'd2:    w = 4'd3;
			4'd3:    w = 4'd2;
			4'd4:    w = 4'd9;
			4'd5:    w = 4'd8;
			4'd6:    w = 4'd7;
			4'd7:    w = 4'd6;
			4'd8:    w = 4'd5;
			4'd9:    w = 4'd4;
			4'd10:   w = 4'd3;
			4'd11:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] cnpj_w2(input logic [3:0] p);
		logic [3:0] w;
		case (p)
			4'd0:    w = 4'd6;
			4'd1:    w = 4'd5;
			4'd2:    w = 4'd4;
			4'd3:    w = 4'd3;
			4'd4:    w = 4'd2;
			4'd5:    w = 4'd9;
			4'd6:    w = 4'd8;
			4'd7:    w = 4'd7;
			4'd8:    w = 4'd6;
			4'd9:    w = 4'd5;
			4'd10:   w = 4'd4;
			4'd11:   w = 4'd3;
			4'd12:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	// Check digit from a weighted sum: remainder below 2 gives 0, else 11 - r.
	function automatic logic [3:0] mod11_check(input logic [9:0] sum);
		logic [22:0] prod;
		logic [6:0]  quo;
		logic [9:0]  rem;
		prod = 23'(sum) * 23'(RECIP11);
		quo  = prod[22:16];
		rem  = sum - 10'({3'b000, quo} * 10'd11);
		return (rem < 10'd2) ? 4'd0 : 4'(10'd11 - rem);
	endfunction

endpackage

// ----- sv/cpfcv_front.sv -----
module cpfcv_front (
	input  cpfcv_pkg::in_t    in_data,
	output cpfcv_pkg::entry_t entry
);

	logic is_digit;

	assign is_digit = (in_data.char_in >= cpfcv_pkg::CHAR_ZERO)
		&& (in_data.char_in <= cpfcv_pkg::CHAR_NINE);

	always_comb begin
		entry.is_digit = is_digit;
		entry.digit    = is_digit ? 4'(in_data.char_in - cpfcv_pkg::CHAR_ZERO) : 4'd0;
		entry.last     = in_data.last_char;
	end

endmodule

// ----- sv/cpfcv_queue.sv -----
module cpfcv_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cpfcv_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output cpfcv_pkg::entry_t pop_entry
);

	cpfcv_pkg::entry_t mem_q [cpfcv_pkg::QDEPTH];
	logic [cpfcv_pkg::QAW-1:0] wr_ptr_q;
	logic [cpfcv_pkg::QAW-1:0] rd_ptr_q;
	logic [cpfcv_pkg::QAW:0]   cnt_q;
	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == (cpfcv_pkg::QAW+1)'(cpfcv_pkg::QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- sv/cpfcv_back.sv -----
module cpfcv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        id_mode,
	input  logic              q_valid,
	input  cpfcv_pkg::entry_t q_entry,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output cpfcv_pkg::out_t   out_data
);

	// Running state of the string being collected.
	logic [3:0] cnt_q;
	logic [9:0] cpf1_q, cpf2_q, cnpj1_q, cnpj2_q;
	logic [3:0] lead_q;
	logic       eq_q;
	logic [3:0] held_q [4];

	// Next values with the current beat folded in.
	logic [3:0] cnt_n;
	logic [9:0] cpf1_n, cpf2_n, cnpj1_n, cnpj2_n;
	logic [3:0] lead_n;
	logic       eq_n;
	logic [3:0] held_n [4];

	// Finished sums of one string, waiting for the judge stage.
	logic       valid_s1;
	logic [3:0] cnt_s1;
	logic [9:0] cpf1_s1, cpf2_s1, cnpj1_s1, cnpj2_s1;
	logic       eq_s1;
	logic [3:0] held_s1 [4];

	logic            out_valid_q;
	cpfcv_pkg::out_t out_q;
	cpfcv_pkg::out_t judge;
	logic            out_free;
	logic            s1_free;
	logic [3:0]      p;
	logic [3:0]      d;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	// Plain characters never wait; a last character needs room in the judge stage.
	assign q_pop    = q_valid && (!q_entry.last || s1_free);

	assign p = cnt_q;
	assign d = q_entry.digit;

	always_comb begin
		cnt_n   = cnt_q;
		cpf1_n  = cpf1_q;
		cpf2_n  = cpf2_q;
		cnpj1_n = cnpj1_q;
		cnpj2_n = cnpj2_q;
		lead_n  = lead_q;
		eq_n    = eq_q;
		for (int i = 0; i < 4; i++) begin
			held_n[i] = held_q[i];
		end
		if (q_entry.is_digit) begin
			if (p == 4'd0) begin
				lead_n = d;
			end else if (d != lead_q) begin
				eq_n = 1'b0;
			end
			cpf1_n  = cpf1_q + 10'(d) * 10'(cpfcv_pkg::cpf_w1(p));
			cpf2_n  = cpf2_q + 10'(d) * 10'(cpfcv_pkg::cpf_w2(p));
			cnpj1_n = cnpj1_q + 10'(d) * 10'(cpfcv_pkg::cnpj_w1(p));
			cnpj2_n = cnpj2_q + 10'(d) * 10'(cpfcv_pkg::cnpj_w2(p));
			if (p == cpfcv_pkg::POS_CPF_DV1) begin
				held_n[0] = d;
			end
			if (p == cpfcv_pkg::POS_CPF_DV2) begin
				held_n[1] = d;
			end
			if (p == cpfcv_pkg::POS_CNPJ_DV1) begin
				held_n[2] = d;
			end
			if (p == cpfcv_pkg::POS_CNPJ_DV2) begin
				held_n[3] = d;
			end
			if (cnt_q != cpfcv_pkg::COUNT_MAX) begin
				cnt_n = cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cpf1_q  <= '0;
			cpf2_q  <= '0;
			cnpj1_q <= '0;
			cnpj2_q <= '0;
			lead_q  <= '0;
			eq_q    <= 1'b1;
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= '0;
			end
		end else if (q_pop) begin
			if (q_entry.last) begin
				cnt_q   <= '0;
				cpf1_q  <= '0;
				cpf2_q  <= '0;
				cnpj1_q <= '0;
				cnpj2_q <= '0;
				lead_q  <= '0;
				eq_q    <= 1'b1;
				for (int i = 0; i < 4; i++) begin
					held_q[i] <= '0;
				end
			end else begin
				cnt_q   <= cnt_n;
				cpf1_q  <= cpf1_n;
				cpf2_q  <= cpf2_n;
				cnpj1_q <= cnpj1_n;
				cnpj2_q <= cnpj2_n;
				lead_q  <= lead_n;
				eq_q    <= eq_n;
				for (int i = 0; i < 4; i++) begin
					held_q[i] <= held_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_pop && q_entry.last;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) begin
			cnt_s1   <= cnt_n;
			cpf1_s1  <= cpf1_n;
			cpf2_s1  <= cpf2_n;
			cnpj1_s1 <= cnpj1_n;
			cnpj2_s1 <= cnpj2_n;
			eq_s1    <= eq_n;
			for (int i = 0; i < 4; i++) begin
				held_s1[i] <= held_n[i];
			end
		end
	end

	always_comb begin
		judge.cpf_ok = (cnt_s1 == cpfcv_pkg::CPF_LEN) && !eq_s1
			&& (cpfcv_pkg::mod11_check(cpf1_s1) == held_s1[0])
			&& (cpfcv_pkg::mod11_check(cpf2_s1) == held_s1[1]);
		judge.cnpj_ok = (cnt_s1 == cpfcv_pkg::CNPJ_LEN)
			&& (cpfcv_pkg::mod11_check(cnpj1_s1) == held_s1[2])
			&& (cpfcv_pkg::mod11_check(cnpj2_s1) == held_s1[3]);
		case (id_mode)
			cpfcv_pkg::MODE_CPF:  judge.accepted = judge.cpf_ok;
			cpfcv_pkg::MODE_CNPJ: judge.accepted = judge.cnpj_ok;
			default:              judge.accepted = judge.cpf_ok || judge.cnpj_ok;
		endcase
		judge.digits_seen = cnt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_q <= judge;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(cnt_s1) && $stable(cpf1_s1))
		else $error("judge stage lost or changed a waiting string");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.last |=> cnt_q == 4'd0 && eq_q && cpf1_q == 10'd0)
		else $error("string state not cleared after last character");

	a_last_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_entry.last |=> valid_s1)
		else $error("last character did not reach judge stage");

	a_cpf_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.cpf_ok |-> out_q.digits_seen == cpfcv_pkg::CPF_LEN)
		else $error("CPF pass with wrong length");

	a_cnpj_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.cnpj_ok |-> out_q.digits_seen == cpfcv_pkg::CNPJ_LEN)
		else $error("CNPJ pass with wrong length");

	a_accept_implies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.accepted |-> out_q.cpf_ok || out_q.cnpj_ok)
		else $error("verdict accepted without a passing check");

endmodule

// ----- sv/cpf_cnpj_check_digit_validator.sv -----
// Channel  Direction  Handshake                 Beat
// in       input      in_valid / in_stall       in_data: one character, last mark
// out      output     out_valid / out_stall     out_data: flags and digit count
// cfg      input      cfg_valid / cfg_ready     cfg_data: id_mode
//
// One character is taken every cycle while in_stall is low; the four-entry queue between
// the classifier and the accumulator absorbs output stalls until it fills.
// The result of a string is registered from its accepted last beat into the judge stage
// and then into the output register, and waits there while out_stall is high. Reset clears
// the running sums and sets id_mode to CPF.
module cpf_cnpj_check_digit_validator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cpfcv_pkg::in_t      in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output cpfcv_pkg::out_t     out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	logic [1:0]        id_mode_q;
	cpfcv_pkg::entry_t front_entry;
	cpfcv_pkg::entry_t q_entry;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_mode_q <= cpfcv_pkg::MODE_CPF;
		end else if (cfg_valid && cfg_ready) begin
			id_mode_q <= cfg_data;
		end
	end

	cpfcv_front u_front (
		.in_data (in_data),
		.entry   (front_entry)
	);

	cpfcv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_valid),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry)
	);

	cpfcv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.id_mode   (id_mode_q),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
